/* rtl/tam_pkg.sv */
// Shared types and constants for the temperature alarm monitor.
// Holds the item and result payload structs, alarm codes and register indexes.
// No dependencies.
`default_nettype none

package tam_pkg;

  // Alarm codes as they appear in the result slots.
  localparam logic [2:0] CODE_NONE      = 3'd0;
  localparam logic [2:0] CODE_PIT_HIGH  = 3'd1;
  localparam logic [2:0] CODE_PIT_LOW   = 3'd2;
  localparam logic [2:0] CODE_PROBE_ONE = 3'd3;
  localparam logic [2:0] CODE_PROBE_TWO = 3'd4;

  // Item kinds.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_ACK    = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] CFG_PROBE_ONE_TARGET = 3'd0;
  localparam logic [2:0] CFG_PROBE_TWO_TARGET = 3'd1;
  localparam logic [2:0] CFG_PIT_BAND         = 3'd2;
  localparam logic [2:0] CFG_ALARM_ENABLE     = 3'd3;
  localparam logic [2:0] CFG_BEEP_ON_MS       = 3'd4;
  localparam logic [2:0] CFG_BEEP_OFF_MS      = 3'd5;

  localparam int CFG_DATA_W = 16;

  // Reset values of the configuration registers.
  localparam logic [13:0] PIT_BAND_RESET = 14'd240;
  localparam logic [15:0] BEEP_MS_RESET  = 16'd500;

  // One input item.
  typedef struct packed {
    logic               kind;
    logic signed [15:0] pit_temp;
    logic signed [15:0] probe_one_temp;
    logic signed [15:0] probe_two_temp;
    logic signed [15:0] pit_setpoint;
    logic               pit_reached;
    logic [31:0]        now_ms;
  } item_t;

  // One result item.
  typedef struct packed {
    logic       buzzer_on;
    logic       alarming;
    logic [2:0] active_count;
    logic [2:0] slot_zero;
    logic [2:0] slot_one;
    logic [2:0] slot_two;
    logic [2:0] slot_three;
  } result_t;

  // Acknowledge flag and trigger latches.
  typedef struct packed {
    logic acked;
    logic pit_latch;
    logic probe_one_latch;
    logic probe_two_latch;
  } flags_t;

  // Settings the list logic needs.
  typedef struct packed {
    logic [14:0] probe_one_target;
    logic [14:0] probe_two_target;
    logic [13:0] pit_band;
    logic        alarm_enable;
  } list_cfg_t;

endpackage

`default_nettype wire

/* rtl/tam_list.sv */
// Next-state logic of the active alarm list, latches and acknowledge flag.
// Evaluates one item against the current list in a single pass.
// Depends on tam_pkg.
`default_nettype none

module tam_list #(
  parameter int MAX_ALARMS = 4
) (
  input  tam_pkg::item_t                  item,
  input  tam_pkg::list_cfg_t              cfg,
  input  logic [MAX_ALARMS-1:0][2:0]      list_cur,
  input  logic [2:0]                      count_cur,
  input  tam_pkg::flags_t                 flags_cur,
  output logic [MAX_ALARMS-1:0][2:0]      list_next,
  output logic [2:0]                      count_next,
  output tam_pkg::flags_t                 flags_next
);

  typedef logic [MAX_ALARMS-1:0][2:0] list_t;

  localparam logic [2:0] MAX_COUNT = 3'(MAX_ALARMS);

  // True when the code sits in one of the occupied entries.
  function automatic logic listed(list_t lst, logic [2:0] cnt, logic [2:0] code);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < MAX_ALARMS; k++) begin
      if (3'(k) < cnt && lst[k] == code) hit = 1'b1;
    end
    return hit;
  endfunction

  // Writes the code into the first free entry.
  function automatic list_t appended(list_t lst, logic [2:0] cnt, logic [2:0] code);
    list_t r;
    r = lst;
    for (int k = 0; k < MAX_ALARMS; k++) begin
      if (3'(k) == cnt) r[k] = code;
    end
    return r;
  endfunction

  // Drops the code and closes the gap, keeping the order of the rest.
  function automatic list_t removed(list_t lst, logic [2:0] cnt, logic [2:0] code);
    logic [MAX_ALARMS:0][2:0] ext;
    list_t r;
    logic hit;
    ext = {tam_pkg::CODE_NONE, lst};
    r   = lst;
    hit = 1'b0;
    for (int k = 0; k < MAX_ALARMS; k++) begin
      if (3'(k) < cnt && lst[k] == code) hit = 1'b1;
      if (hit) r[k] = ext[k+1];
    end
    return r;
  endfunction

  // Band limits and probe comparisons, all in wide signed arithmetic.
  logic signed [17:0] pit_ext;
  logic signed [17:0] hi_lim;
  logic signed [17:0] lo_lim;
  logic               pit_check;
  logic               pit_out;
  logic               pit_above;
  logic               probe_one_hit;
  logic               probe_two_hit;

  always_comb begin
    pit_ext   = 18'(item.pit_temp);
    hi_lim    = 18'(item.pit_setpoint) + $signed({4'b0, cfg.pit_band});
    lo_lim    = 18'(item.pit_setpoint) - $signed({4'b0, cfg.pit_band});
    pit_check = item.pit_reached && item.pit_setpoint > 16'sd0 && item.pit_temp > 16'sd0;
    pit_above = pit_ext > hi_lim;
    pit_out   = pit_above || pit_ext < lo_lim;
    probe_one_hit = cfg.probe_one_target != 15'd0 && item.probe_one_temp > 16'sd0 &&
                    $signed({item.probe_one_temp[15], item.probe_one_temp}) >=
                    $signed({2'b0, cfg.probe_one_target});
    probe_two_hit = cfg.probe_two_target != 15'd0 && item.probe_two_temp > 16'sd0 &&
                    $signed({item.probe_two_temp[15], item.probe_two_temp}) >=
                    $signed({2'b0, cfg.probe_two_target});
  end

  // Apply the item: acknowledge, or pit then probe one then probe two.
  always_comb begin
    list_t           lst;
    logic [2:0]      cnt;
    tam_pkg::flags_t fl;
    logic [2:0]      code;
    lst  = list_cur;
    cnt  = count_cur;
    fl   = flags_cur;
    code = tam_pkg::CODE_NONE;
    if (item.kind == tam_pkg::KIND_ACK) begin
      // Latch every listed alarm so it does not refire, then empty the list.
      for (int k = 0; k < MAX_ALARMS; k++) begin
        if (3'(k) < cnt) begin
          case (lst[k])
            tam_pkg::CODE_PIT_HIGH, tam_pkg::CODE_PIT_LOW: fl.pit_latch = 1'b1;
            tam_pkg::CODE_PROBE_ONE: fl.probe_one_latch = 1'b1;
            tam_pkg::CODE_PROBE_TWO: fl.probe_two_latch = 1'b1;
            default: ;
          endcase
        end
      end
      lst      = '0;
      cnt      = 3'd0;
      fl.acked = 1'b1;
    end else if (cfg.alarm_enable) begin
      // Pit alarm: raise outside the band, clear both when back in band.
      if (pit_check) begin
        if (pit_out && !fl.pit_latch) begin
          code = pit_above ? tam_pkg::CODE_PIT_HIGH : tam_pkg::CODE_PIT_LOW;
          if (!listed(lst, cnt, code) && cnt < MAX_COUNT) begin
            lst      = appended(lst, cnt, code);
            cnt      = cnt + 3'd1;
            fl.acked = 1'b0;
          end
        end else if (!pit_out) begin
          if (listed(lst, cnt, tam_pkg::CODE_PIT_HIGH)) begin
            lst = removed(lst, cnt, tam_pkg::CODE_PIT_HIGH);
            cnt = cnt - 3'd1;
          end
          if (listed(lst, cnt, tam_pkg::CODE_PIT_LOW)) begin
            lst = removed(lst, cnt, tam_pkg::CODE_PIT_LOW);
            cnt = cnt - 3'd1;
          end
          fl.pit_latch = 1'b0;
        end
      end
      // Probe one done.
      if (probe_one_hit && !fl.probe_one_latch) begin
        if (!listed(lst, cnt, tam_pkg::CODE_PROBE_ONE) && cnt < MAX_COUNT) begin
          lst      = appended(lst, cnt, tam_pkg::CODE_PROBE_ONE);
          cnt      = cnt + 3'd1;
          fl.acked = 1'b0;
        end
        fl.probe_one_latch = 1'b1;
      end
      // Probe two done.
      if (probe_two_hit && !fl.probe_two_latch) begin
        if (!listed(lst, cnt, tam_pkg::CODE_PROBE_TWO) && cnt < MAX_COUNT) begin
          lst      = appended(lst, cnt, tam_pkg::CODE_PROBE_TWO);
          cnt      = cnt + 3'd1;
          fl.acked = 1'b0;
        end
        fl.probe_two_latch = 1'b1;
      end
    end
    list_next  = lst;
    count_next = cnt;
    flags_next = fl;
  end

endmodule

`default_nettype wire

/* rtl/tam_buzz.sv */
// Buzzer blink timing for the temperature alarm monitor.
// Toggles the buzzer when the on or off time has elapsed while alarming.
// Does not depend on tam_pkg; the top level drives it.
`default_nettype none

module tam_buzz (
  input  logic        force_off,
  input  logic        alarming,
  input  logic        buzzer_cur,
  input  logic [31:0] last_cur,
  input  logic [31:0] now_ms,
  input  logic [15:0] beep_on_ms,
  input  logic [15:0] beep_off_ms,
  output logic        buzzer_next,
  output logic [31:0] last_next
);

  logic [31:0] elapsed;
  logic [31:0] limit;

  // Elapsed time wraps with the millisecond counter.
  assign elapsed = now_ms - last_cur;
  assign limit   = buzzer_cur ? {16'b0, beep_on_ms} : {16'b0, beep_off_ms};

  // Toggle on timeout; silence when not alarming or forced off.
  always_comb begin
    buzzer_next = buzzer_cur;
    last_next   = last_cur;
    if (force_off || !alarming) begin
      buzzer_next = 1'b0;
    end else if (elapsed >= limit) begin
      buzzer_next = !buzzer_cur;
      last_next   = now_ms;
    end
  end

endmodule

`default_nettype wire

/* rtl/temperature_alarm_monitor_unit.sv */
// Temperature alarm monitor: the item stage, state registers and result register.
// Instantiates tam_list and tam_buzz; depends on tam_pkg.
//
// Usage: each item on the item channel is either a temperature sample or a user
// acknowledge (kind). Every accepted item yields exactly one result transfer
// carrying the buzzer drive, the alarming flag, the alarm count and the four
// list slots, oldest alarm first.
// Timing: the item is registered in the item register, and one pass of list and
// buzzer logic then loads the result register, which raises result_valid; a
// blocked result register holds the item in the item register. Throughput:
// one item per cycle while result_stall is low, since the list update is a single
// short pass over the MAX_ALARMS entries.
// Stalls: a result waits in the result register while result_stall is high;
// one more item can be held in the item register, after which item_stall rises.
// Reset: synchronous, clears the list, latches, buzzer and blink timer and loads the
// register defaults (band 240, enable on, 500 ms on and off). Configuration writes
// take effect at once; the user must make them only while idle; the block does not check this.
`default_nettype none

module temperature_alarm_monitor_unit #(
  parameter int MAX_ALARMS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  tam_pkg::item_t                      item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output tam_pkg::result_t                    result,
  input  logic                                cfg_wr_en,
  input  logic [2:0]                          cfg_index,
  input  logic [tam_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Configuration registers.
  tam_pkg::list_cfg_t cfg;
  logic [15:0]        beep_on_ms;
  logic [15:0]        beep_off_ms;

  // Item stage.
  logic           stage_valid;
  tam_pkg::item_t stage_item;
  logic           advance;
  logic           item_accept;

  // Alarm state.
  logic [MAX_ALARMS-1:0][2:0] alarm_list;
  logic [MAX_ALARMS-1:0][2:0] alarm_list_next;
  logic [2:0]                 alarm_count;
  logic [2:0]                 alarm_count_next;
  tam_pkg::flags_t            flags;
  tam_pkg::flags_t            flags_next;
  logic                       buzzer;
  logic                       buzzer_next;
  logic [31:0]                last_toggle_ms;
  logic [31:0]                last_toggle_ms_next;
  logic                       alarming_next;
  logic                       force_off;
  logic [3:0][2:0]            slot_v;

  // Handshake: the item stage moves whenever the result register is free or draining.
  assign advance     = stage_valid && (!result_valid || !result_stall);
  assign item_stall  = stage_valid && !advance;
  assign item_accept = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      stage_item <= item;
    end
  end

  // List, latch and acknowledge update.
  tam_list #(
    .MAX_ALARMS (MAX_ALARMS)
  ) u_list (
    .item       (stage_item),
    .cfg        (cfg),
    .list_cur   (alarm_list),
    .count_cur  (alarm_count),
    .flags_cur  (flags),
    .list_next  (alarm_list_next),
    .count_next (alarm_count_next),
    .flags_next (flags_next)
  );

  assign alarming_next = alarm_count_next != 3'd0 && !flags_next.acked;
  assign force_off     = stage_item.kind == tam_pkg::KIND_ACK || !cfg.alarm_enable;

  // Buzzer blink timing.
  tam_buzz u_buzz (
    .force_off   (force_off),
    .alarming    (alarming_next),
    .buzzer_cur  (buzzer),
    .last_cur    (last_toggle_ms),
    .now_ms      (stage_item.now_ms),
    .beep_on_ms  (beep_on_ms),
    .beep_off_ms (beep_off_ms),
    .buzzer_next (buzzer_next),
    .last_next   (last_toggle_ms_next)
  );

  // State registers; configuration side effects apply only when the item stage does not advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_list     <= '0;
      alarm_count    <= 3'd0;
      flags          <= '0;
      buzzer         <= 1'b0;
      last_toggle_ms <= 32'd0;
    end else if (advance) begin
      alarm_list     <= alarm_list_next;
      alarm_count    <= alarm_count_next;
      flags          <= flags_next;
      buzzer         <= buzzer_next;
      last_toggle_ms <= last_toggle_ms_next;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tam_pkg::CFG_PROBE_ONE_TARGET: flags.probe_one_latch <= 1'b0;
        tam_pkg::CFG_PROBE_TWO_TARGET: flags.probe_two_latch <= 1'b0;
        tam_pkg::CFG_ALARM_ENABLE: begin
          if (!cfg_data[0]) buzzer <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.probe_one_target <= 15'd0;
      cfg.probe_two_target <= 15'd0;
      cfg.pit_band         <= tam_pkg::PIT_BAND_RESET;
      cfg.alarm_enable     <= 1'b1;
      beep_on_ms           <= tam_pkg::BEEP_MS_RESET;
      beep_off_ms          <= tam_pkg::BEEP_MS_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tam_pkg::CFG_PROBE_ONE_TARGET: cfg.probe_one_target <= cfg_data[14:0];
        tam_pkg::CFG_PROBE_TWO_TARGET: cfg.probe_two_target <= cfg_data[14:0];
        tam_pkg::CFG_PIT_BAND: begin
          if (cfg_data[13:0] != 14'd0) cfg.pit_band <= cfg_data[13:0];
        end
        tam_pkg::CFG_ALARM_ENABLE: cfg.alarm_enable <= cfg_data[0];
        tam_pkg::CFG_BEEP_ON_MS:   beep_on_ms       <= cfg_data[15:0];
        tam_pkg::CFG_BEEP_OFF_MS:  beep_off_ms      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Slots past the configured depth or the count read as none.
  always_comb begin
    slot_v = '0;
    for (int k = 0; k < MAX_ALARMS; k++) begin
      if (3'(k) < alarm_count_next) slot_v[k] = alarm_list_next[k];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.buzzer_on    <= buzzer_next;
      result.alarming     <= alarming_next;
      result.active_count <= alarm_count_next;
      result.slot_zero    <= slot_v[0];
      result.slot_one     <= slot_v[1];
      result.slot_two     <= slot_v[2];
      result.slot_three   <= slot_v[3];
    end
  end

  // The buzzer only sounds while an unacknowledged alarm is listed.
  a_buzzer_needs_alarm: assert property (@(posedge clk) disable iff (rst)
    buzzer |-> (alarm_count != 3'd0 && !flags.acked))
    else $error("buzzer on without an active alarm");

  // The list never grows past its depth.
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    alarm_count <= 3'(MAX_ALARMS))
    else $error("alarm count exceeds list depth");

  // An empty list reports no alarm in the oldest slot and no alarming flag.
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.active_count == 3'd0) |->
      (result.slot_zero == tam_pkg::CODE_NONE && !result.alarming))
    else $error("empty list reported with an alarm");

  // A held item and a blocked result register must stall the item channel.
  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && result_valid && result_stall) |-> item_stall)
    else $error("item accepted with no room");

  // A result transfer with nothing behind it empties the result register.
  a_result_drains: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && !stage_valid) |=> !result_valid)
    else $error("result repeated");

endmodule

`default_nettype wire
